### rtl/core/ring_stamp_opening_check_assert.svh
// Assertion macros shared by the RTL of the ring opening checker.
// Define NO_ASSERTIONS to compile the design without any checks.
`ifndef RING_STAMP_OPENING_CHECK_ASSERT_SVH
`define RING_STAMP_OPENING_CHECK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition and consequence in the same cycle.
`define RSOC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rsoc assertion failed");

// Consequence in the cycle after the condition.
`define RSOC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rsoc assertion failed");

`else

`define RSOC_ASSERT_NOW(label, clk, rstn, ante, cons)
`define RSOC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### rtl/core/rsoc_pkg.sv
`default_nettype none

package rsoc_pkg;

    localparam int TDATA_W      = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_W     = 16;
    localparam int WIDTH_RESET  = 3;
    localparam int HEIGHT_RESET = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    // Control that travels with a pixel from the address stage to the
    // line memory stage. Row and column flags are relative to the pixel.
    typedef struct packed {
        logic pix;
        logic end_row;
        logic last_row;
        logic last_item;
        logic r_ge1;
        logic r_ge2;
        logic r_ge3;
        logic r_ge4;
        logic c_ge1;
        logic c_ge2;
        logic c_ge3;
    } s1_ctl_t;

    // Compares one pixel column against the ring coverage of its three
    // neighboring centre columns. Triples carry rows r-1, r-2, r-3 in bits
    // 0, 1, 2 for centres and rows r, r-1, r-2 in bits 0, 1, 2 for pixels.
    // Row r only sees centres of row r-1; row r-1 sees rows r-2 and r-1.
    function automatic logic ring_miss(input logic [2:0] pix,
                                       input logic [2:0] left,
                                       input logic [2:0] mid,
                                       input logic [2:0] right,
                                       input logic       chk2,
                                       input logic       chk1,
                                       input logic       chk0);
        logic cov2;
        logic cov1;
        logic cov0;
        cov2 = (|left) | (|right) | mid[0] | mid[2];
        cov1 = (|left[1:0]) | (|right[1:0]) | mid[1];
        cov0 = left[0] | mid[0] | right[0];
        return (chk2 && (pix[2] != cov2)) ||
               (chk1 && (pix[1] != cov1)) ||
               (chk0 && (pix[0] != cov0));
    endfunction

endpackage

`default_nettype wire

### rtl/core/ring_stamp_opening_check.sv
// The verdict for an image is registered once its last pixel leaves stage 1.
// Throughput: one pixel per cycle; input stalls only while a finished verdict is not taken
// and the pixel in the memory stage is itself the last one of an image.
// Reset (aresetn low, synchronous): counters, valid flags and the verdict clear; width and
// height return to 3. The two line memories are not cleared; rows not yet written are masked.
`default_nettype none

`include "ring_stamp_opening_check_assert.svh"

module ring_stamp_opening_check
    import rsoc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    // Pixel stream. s_tdata fields from bit 0: pixel (1 bit), zero fill.
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [TDATA_W-1:0]     s_tdata,
    // Verdict stream. m_tdata fields from bit 0: is_stampable (1 bit), zero fill.
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [TDATA_W-1:0]     m_tdata,
    // Register writes: index 0 is image_width, index 1 is image_height.
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_data
);

    // The design is a two stage pipe around two line memories, one entry per
    // column. Stage 0 holds the raster counters and issues the memory reads
    // for the column of the incoming pixel. Stage 1 receives the read data,
    // forms a 3x3 window from small column history registers, evaluates the
    // stamp centre one row up and one column left, checks the pixels of column
    // c-2 (at row ends also c-1 and c) and writes the updated entries back.
    //
    // The pixel memory keeps rows r-1 and r-2 of each column. The centre
    // memory keeps the centre flags of rows r-2 and r-3. The newest centre
    // row (r-1) is produced on the fly in stage 1 and written back with a
    // lag of one column, because a centre is known only once the pixel to
    // its lower right has arrived.

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
    localparam logic [CMP_W-1:0] MAXW_EXT = CMP_W'(MAX_WIDTH);

    // ------------------------------------------------------------------
    // Configuration. The effective last column and last row are kept
    // instead of the raw values: a zero size acts as one and a width over
    // the memory depth acts as the depth.
    // ------------------------------------------------------------------
    logic [CW-1:0]       last_col_reg;
    logic [CW-1:0]       last_col_next;
    logic [HEIGHT_W-1:0] last_row_reg;
    logic [HEIGHT_W-1:0] last_row_next;
    logic [CMP_W-1:0]    wval_ext;
    logic [HEIGHT_W-1:0] hval;
    logic                cfg_wr;
    logic                cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign wval_ext  = CMP_W'(cfg_data[WIDTH_REG_W-1:0]);
    assign hval      = cfg_data[HEIGHT_W-1:0];

    always_comb begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        cfg_hit       = 1'b0;
        if (cfg_wr) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    cfg_hit = 1'b1;
                    if (wval_ext == '0) begin
                        last_col_next = '0;
                    end else if (wval_ext > MAXW_EXT) begin
                        last_col_next = CW'(MAXW_EXT - 1'b1);
                    end else begin
                        last_col_next = CW'(wval_ext - 1'b1);
                    end
                end
                REG_IMAGE_HEIGHT: begin
                    cfg_hit = 1'b1;
                    if (hval == '0) begin
                        last_row_next = '0;
                    end else begin
                        last_row_next = hval - 1'b1;
                    end
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. Stage 1 only waits when it holds the last pixel of an
    // image and the previous verdict has not been taken yet.
    // ------------------------------------------------------------------
    logic          s_accept;
    logic          s1_valid_reg;
    s1_ctl_t       s1_ctl_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_go;
    logic          m_tvalid_reg;
    logic          m_result_reg;

    assign s_tready = !(s1_valid_reg && s1_ctl_reg.last_item && m_tvalid_reg);
    assign s_accept = s_tvalid && s_tready;
    assign s1_go    = s1_valid_reg &&
                      (!s1_ctl_reg.last_item || !m_tvalid_reg || m_tready);

    // ------------------------------------------------------------------
    // Stage 0: raster position of the next pixel.
    // ------------------------------------------------------------------
    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [HEIGHT_W-1:0] row_reg;
    logic [HEIGHT_W-1:0] row_next;
    s1_ctl_t             s0_ctl;

    always_comb begin
        s0_ctl.pix       = s_tdata[0];
        s0_ctl.end_row   = (col_reg == last_col_reg);
        s0_ctl.last_row  = (row_reg == last_row_reg);
        s0_ctl.last_item = s0_ctl.end_row && s0_ctl.last_row;
        s0_ctl.r_ge1     = (row_reg >= 16'd1);
        s0_ctl.r_ge2     = (row_reg >= 16'd2);
        s0_ctl.r_ge3     = (row_reg >= 16'd3);
        s0_ctl.r_ge4     = (row_reg >= 16'd4);
        s0_ctl.c_ge1     = (col_reg >= CW'(1));
        s0_ctl.c_ge2     = (col_reg >= CW'(2));
        s0_ctl.c_ge3     = (col_reg >= CW'(3));
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (s_accept) begin
            if (s0_ctl.end_row) begin
                col_next = '0;
                row_next = s0_ctl.last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line memories with registered reads. A write from stage 1 to
    // the entry being read in the same cycle is forwarded; that happens for
    // the pixel memory at width one and the centre memory at width two.
    // ------------------------------------------------------------------
    logic [1:0] pix_mem [MAX_WIDTH];
    logic [1:0] ctr_mem [MAX_WIDTH];
    logic [1:0] pix_q_reg;
    logic [1:0] ctr_q_reg;
    logic       pix_we;
    logic [1:0] pix_wdata;
    logic       ctr_we;
    logic [CW-1:0] ctr_waddr;
    logic [1:0] ctr_wdata;

    always_ff @(posedge aclk) begin
        if (pix_we) begin
            pix_mem[s1_col_reg] <= pix_wdata;
        end
        if (s_accept) begin
            pix_q_reg <= (pix_we && (s1_col_reg == col_reg)) ? pix_wdata : pix_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctr_we) begin
            ctr_mem[ctr_waddr] <= ctr_wdata;
        end
        if (s_accept) begin
            ctr_q_reg <= (ctr_we && (ctr_waddr == col_reg)) ? ctr_wdata : ctr_mem[col_reg];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window, centre, checks and write back.
    // ------------------------------------------------------------------
    logic [2:0] pw1_reg;    // pixel rows r, r-1, r-2 of column c-1
    logic [2:0] pw2_reg;    // same for column c-2
    logic [1:0] mw1_reg;    // centre rows r-2 (bit 0) and r-3 (bit 1) of column c-1
    logic [2:0] t2_reg;     // centre rows r-1, r-2, r-3 of column c-2
    logic [2:0] t3_reg;     // same for column c-3
    logic       mism_reg;
    logic       mism_next;

    logic [2:0] pc;         // pixel triple of the current column
    logic [2:0] pa;
    logic [2:0] pb;
    logic [2:0] ca;
    logic [2:0] cb;
    logic [2:0] cc;
    logic [2:0] tc;
    logic [1:0] mw_in;
    logic       cnew;
    logic       chk2;
    logic       chk1;
    logic       chk0;
    logic       miss;

    always_comb begin
        // Rows above row 0 of this image may hold anything, so mask them.
        pc    = {pix_q_reg[1] & s1_ctl_reg.r_ge2,
                 pix_q_reg[0] & s1_ctl_reg.r_ge1,
                 s1_ctl_reg.pix};
        mw_in = {ctr_q_reg[1] & s1_ctl_reg.r_ge4,
                 ctr_q_reg[0] & s1_ctl_reg.r_ge3};

        // Columns left of column 0 read as clear.
        pa = s1_ctl_reg.c_ge2 ? pw2_reg : 3'b000;
        pb = s1_ctl_reg.c_ge1 ? pw1_reg : 3'b000;

        // The centre of row r-1 at column c-1 needs all of columns c-2 and
        // c and the top and bottom of column c-1.
        cnew = s1_ctl_reg.r_ge2 && s1_ctl_reg.c_ge2 &&
               (pa == 3'b111) && (pc == 3'b111) && pb[0] && pb[2];

        tc = {mw1_reg, cnew};
        ca = s1_ctl_reg.c_ge3 ? t3_reg : 3'b000;
        cb = s1_ctl_reg.c_ge2 ? t2_reg : 3'b000;
        cc = s1_ctl_reg.c_ge1 ? tc : 3'b000;

        // Row r-2 is final once row r is through; on the last row of the
        // image rows r-1 and r are checked too. The last column never holds
        // a centre, so the column right of the current one reads as clear.
        chk2 = s1_ctl_reg.r_ge2;
        chk1 = s1_ctl_reg.last_row && s1_ctl_reg.r_ge1;
        chk0 = s1_ctl_reg.last_row;

        miss = 1'b0;
        if (s1_ctl_reg.c_ge2) begin
            miss = miss | ring_miss(pa, ca, cb, cc, chk2, chk1, chk0);
        end
        if (s1_ctl_reg.end_row && s1_ctl_reg.c_ge1) begin
            miss = miss | ring_miss(pb, cb, cc, 3'b000, chk2, chk1, chk0);
        end
        if (s1_ctl_reg.end_row) begin
            miss = miss | ring_miss(pc, cc, 3'b000, 3'b000, chk2, chk1, chk0);
        end

        pix_we    = s1_go;
        pix_wdata = pc[1:0];
        ctr_we    = s1_go && s1_ctl_reg.c_ge1;
        ctr_waddr = s1_col_reg - 1'b1;
        ctr_wdata = {mw1_reg[0], cnew};

        mism_next = mism_reg;
        if (cfg_hit) begin
            mism_next = 1'b0;
        end else if (s1_go) begin
            mism_next = s1_ctl_reg.last_item ? 1'b0 : (mism_reg | miss);
        end
    end

    // Window history advances with every pixel that leaves stage 1.
    always_ff @(posedge aclk) begin
        if (s1_go) begin
            pw2_reg <= pw1_reg;
            pw1_reg <= pc;
            t3_reg  <= t2_reg;
            t2_reg  <= tc;
            mw1_reg <= mw_in;
        end
        if (s_accept) begin
            s1_ctl_reg <= s0_ctl;
            s1_col_reg <= col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= CW'(WIDTH_RESET - 1);
            last_row_reg <= HEIGHT_W'(HEIGHT_RESET - 1);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            mism_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_result_reg <= 1'b0;
        end else begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            mism_reg     <= mism_next;
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go && s1_ctl_reg.last_item) begin
                m_tvalid_reg <= 1'b1;
                m_result_reg <= !(mism_reg | miss);
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_W-1){1'b0}}, m_result_reg};

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `RSOC_ASSERT_NOW(a_accept_frees_stage, aclk, aresetn, s_accept, (!s1_valid_reg || s1_go))
    `RSOC_ASSERT_NEXT(a_verdict_from_last, aclk, aresetn, (!m_tvalid_reg && !(s1_go && s1_ctl_reg.last_item)), !m_tvalid_reg)
    `RSOC_ASSERT_NOW(a_col_in_row, aclk, aresetn, 1'b1, (col_reg <= last_col_reg))
    `RSOC_ASSERT_NEXT(a_pos_holds, aclk, aresetn, (!s_accept && !cfg_hit), ($stable(col_reg) && $stable(row_reg)))

endmodule

`default_nettype wire
